// ===== src/abd_pkg.sv =====
// ----------------------------------------------------------------------------
// abd_pkg
// shared types and constants of the acars block deframer
// ----------------------------------------------------------------------------
package abd_pkg;

  // framing bytes
  localparam logic [7:0] SynByte = 8'h16;
  localparam logic [7:0] SynInv  = 8'hE9;
  localparam logic [7:0] SohByte = 8'h01;
  localparam logic [7:0] EtxByte = 8'h83;
  localparam logic [7:0] EtbByte = 8'h97;
  localparam logic [7:0] DleByte = 8'h7F;

  localparam logic [3:0] BitsPerByte = 4'd8;

  // configuration reset values
  localparam logic [3:0] MaxPerrReset = 4'd3;
  localparam logic [7:0] DleMinReset  = 8'd20;
  localparam logic [7:0] MaxLenReset  = 8'd240;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    ST_WSYN,
    ST_SYN2,
    ST_SOH1,
    ST_TXT,
    ST_CRC1,
    ST_CRC2,
    ST_END
  } frame_state_e;

  typedef enum logic [1:0] {
    EV_TEXT  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    REG_MAX_PERR = 2'd0,
    REG_DLE_MIN  = 2'd1,
    REG_MAX_LEN  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [3:0] max_parity_errors;
    logic [7:0] dle_min_length;
    logic [7:0] max_text_length;
  } cfg_t;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  data;
    logic        pbad;
    logic [7:0]  len;
    logic [7:0]  crc_first;
    logic [7:0]  crc_second;
    logic [4:0]  perr;
  } frame_ev_t;

endpackage

// ===== src/abd_front.sv =====
// ----------------------------------------------------------------------------
// abd_front
// bit shifter, sync hunt and frame state machine; classifies each byte
// ----------------------------------------------------------------------------
module abd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abd_pkg::cfg_t     cfg_i,
  input  logic              bit_valid_i,
  input  logic              line_bit_i,
  output logic              ev_valid_o,
  output abd_pkg::frame_ev_t ev_o
);

  abd_pkg::frame_state_e state_q, state_d;
  logic [7:0] shifter_q, shifter_d;
  logic [3:0] bits_q, bits_d;
  logic       inv_q, inv_d;
  logic [7:0] count_q, count_d;
  logic [4:0] perr_q, perr_d;
  logic [7:0] recent0_q, recent0_d;
  logic [7:0] recent1_q, recent1_d;
  logic [7:0] held_q, held_d;

  logic [7:0] byte_w;
  logic [8:0] newcount;
  logic [8:0] trimmed;
  logic       bad;
  logic [4:0] perr_inc;
  logic [4:0] perr_lim;

  assign byte_w   = {line_bit_i ^ inv_q, shifter_q[7:1]};
  assign newcount = {1'b0, count_q} + 9'd1;
  assign trimmed  = (newcount >= 9'd3) ? (newcount - 9'd3) : 9'd0;
  assign bad      = ~(^byte_w);
  assign perr_inc = perr_q + 5'd1;
  assign perr_lim = {1'b0, cfg_i.max_parity_errors} + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= abd_pkg::ST_WSYN;
      shifter_q <= '0;
      bits_q    <= '0;
      inv_q     <= 1'b0;
      count_q   <= '0;
      perr_q    <= '0;
      recent0_q <= '0;
      recent1_q <= '0;
      held_q    <= '0;
    end else begin
      state_q   <= state_d;
      shifter_q <= shifter_d;
      bits_q    <= bits_d;
      inv_q     <= inv_d;
      count_q   <= count_d;
      perr_q    <= perr_d;
      recent0_q <= recent0_d;
      recent1_q <= recent1_d;
      held_q    <= held_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    shifter_d  = shifter_q;
    bits_d     = bits_q;
    inv_d      = inv_q;
    count_d    = count_q;
    perr_d     = perr_q;
    recent0_d  = recent0_q;
    recent1_d  = recent1_q;
    held_d     = held_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;
    ev_o.kind  = abd_pkg::EV_TEXT;

    if (bit_valid_i) begin
      shifter_d = byte_w;
      if (bits_q > 4'd1) begin
        bits_d = bits_q - 4'd1;
      end else begin
        case (state_q)
          abd_pkg::ST_SYN2: begin
            if (byte_w == abd_pkg::SynByte) begin
              state_d = abd_pkg::ST_SOH1;
              bits_d  = abd_pkg::BitsPerByte;
            end else if (byte_w == abd_pkg::SynInv) begin
              inv_d  = ~inv_q;
              bits_d = abd_pkg::BitsPerByte;
            end else begin
              state_d = abd_pkg::ST_WSYN;
              bits_d  = 4'd1;
            end
          end
          abd_pkg::ST_SOH1: begin
            if (byte_w == abd_pkg::SohByte) begin
              state_d   = abd_pkg::ST_TXT;
              count_d   = '0;
              perr_d    = '0;
              recent0_d = '0;
              recent1_d = '0;
              bits_d    = abd_pkg::BitsPerByte;
            end else begin
              state_d = abd_pkg::ST_WSYN;
              bits_d  = 4'd1;
            end
          end
          abd_pkg::ST_TXT: begin
            ev_valid_o = 1'b1;
            if (bad) begin
              perr_d = perr_inc;
            end
            if ((bad && (perr_inc > perr_lim)) || newcount[8]) begin
              // parity limit or count overflow
              state_d   = abd_pkg::ST_WSYN;
              bits_d    = 4'd1;
              ev_o.kind = abd_pkg::EV_ABORT;
            end else begin
              count_d = newcount[7:0];
              if ((byte_w == abd_pkg::EtxByte) || (byte_w == abd_pkg::EtbByte)) begin
                state_d   = abd_pkg::ST_CRC1;
                bits_d    = abd_pkg::BitsPerByte;
                ev_o.data = byte_w;
                ev_o.pbad = bad;
              end else if ((newcount > {1'b0, cfg_i.dle_min_length}) &&
                           (byte_w == abd_pkg::DleByte)) begin
                // crc taken from the two bytes before the dle
                count_d         = trimmed[7:0];
                state_d         = abd_pkg::ST_END;
                bits_d          = abd_pkg::BitsPerByte;
                ev_o.kind       = abd_pkg::EV_DONE;
                ev_o.len        = trimmed[7:0];
                ev_o.crc_first  = recent1_q;
                ev_o.crc_second = recent0_q;
              end else if (newcount > {1'b0, cfg_i.max_text_length}) begin
                state_d   = abd_pkg::ST_WSYN;
                bits_d    = 4'd1;
                ev_o.kind = abd_pkg::EV_ABORT;
              end else begin
                recent1_d = recent0_q;
                recent0_d = byte_w;
                bits_d    = abd_pkg::BitsPerByte;
                ev_o.data = byte_w;
                ev_o.pbad = bad;
              end
            end
          end
          abd_pkg::ST_CRC1: begin
            held_d  = byte_w;
            state_d = abd_pkg::ST_CRC2;
            bits_d  = abd_pkg::BitsPerByte;
          end
          abd_pkg::ST_CRC2: begin
            state_d         = abd_pkg::ST_END;
            bits_d          = abd_pkg::BitsPerByte;
            ev_valid_o      = 1'b1;
            ev_o.kind       = abd_pkg::EV_DONE;
            ev_o.len        = count_q;
            ev_o.crc_first  = held_q;
            ev_o.crc_second = byte_w;
          end
          abd_pkg::ST_END: begin
            state_d = abd_pkg::ST_WSYN;
            bits_d  = abd_pkg::BitsPerByte;
          end
          default: begin
            // hunt, also taken by unused codes
            state_d = abd_pkg::ST_WSYN;
            if (byte_w == abd_pkg::SynByte) begin
              state_d = abd_pkg::ST_SYN2;
              bits_d  = abd_pkg::BitsPerByte;
            end else if (byte_w == abd_pkg::SynInv) begin
              inv_d   = ~inv_q;
              state_d = abd_pkg::ST_SYN2;
              bits_d  = abd_pkg::BitsPerByte;
            end else begin
              bits_d = 4'd1;
            end
          end
        endcase
      end
    end
    ev_o.perr = perr_d;
  end

endmodule

// ===== src/abd_queue.sv =====
// ----------------------------------------------------------------------------
// abd_queue
// short fifo of frame events between front and back
// ----------------------------------------------------------------------------
module abd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  abd_pkg::frame_ev_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output abd_pkg::frame_ev_t data_o
);

  abd_pkg::frame_ev_t slots_q [abd_pkg::QueueDepth];
  logic [abd_pkg::QueuePtrW-1:0] wr_q, wr_d;
  logic [abd_pkg::QueuePtrW-1:0] rd_q, rd_d;
  logic [abd_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic do_push;
  logic do_pop;

  assign full_o  = (cnt_q == abd_pkg::QueueCntW'(abd_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == abd_pkg::QueuePtrW'(abd_pkg::QueueDepth - 1)) ? '0 :
             wr_q + abd_pkg::QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == abd_pkg::QueuePtrW'(abd_pkg::QueueDepth - 1)) ? '0 :
             rd_q + abd_pkg::QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + abd_pkg::QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - abd_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/abd_back.sv =====
// ----------------------------------------------------------------------------
// abd_back
// output register that delivers frame events under downstream stall
// ----------------------------------------------------------------------------
module abd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ev_valid_i,
  input  abd_pkg::frame_ev_t ev_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output abd_pkg::frame_ev_t out_ev_o
);

  logic               valid_q, valid_d;
  abd_pkg::frame_ev_t ev_q;

  assign pop_o       = ev_valid_i && (!valid_q || !out_stall_i);
  assign valid_d     = pop_o || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign out_ev_o    = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q <= ev_i;
    end
  end

endmodule

// ===== src/acars_block_deframer.sv =====
// ----------------------------------------------------------------------------
// acars_block_deframer
// acars block deframer: hunts sync in a bit stream and reports text bytes,
// completed blocks and aborts
// ----------------------------------------------------------------------------
// One demodulated line bit is taken per transfer, and a new bit can be taken
// in every clock cycle while the queue has room. The frame state machine in
// the front part handles each bit in the cycle it is taken: bytes are shifted
// in lsb first, the sync hunt runs bit by bit, and every completed text byte,
// finished block or abort becomes one event. Events go through a two-entry
// queue and an output register, so each result is registered in a queue slot
// and then in the output register. The input stalls only when the queue is
// full, which needs the output side to stall; at most one result follows per
// bit, and in practice at most one every eight bits. The user writes the three
// configuration registers through the cfg port while the block is idle; the
// block itself does not enforce this, and cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module acars_block_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // bit input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       line_bit_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] data_byte_o,
  output logic       byte_parity_bad_o,
  output logic [7:0] block_length_o,
  output logic [7:0] crc_first_o,
  output logic [7:0] crc_second_o,
  output logic [4:0] parity_error_count_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  abd_pkg::cfg_t      cfg_q, cfg_d;
  logic               bit_take;
  logic               fr_valid;
  abd_pkg::frame_ev_t fr_ev;
  logic               q_full;
  logic               q_valid;
  abd_pkg::frame_ev_t q_ev;
  logic               q_pop;
  abd_pkg::frame_ev_t out_ev;

  // configuration registers, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        abd_pkg::REG_MAX_PERR: cfg_d.max_parity_errors = cfg_data_i[3:0];
        abd_pkg::REG_DLE_MIN:  cfg_d.dle_min_length    = cfg_data_i;
        abd_pkg::REG_MAX_LEN:  cfg_d.max_text_length   = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_parity_errors <= abd_pkg::MaxPerrReset;
      cfg_q.dle_min_length    <= abd_pkg::DleMinReset;
      cfg_q.max_text_length   <= abd_pkg::MaxLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // a bit transfer happens whenever a bit is offered and the queue has room
  assign in_stall_o = q_full;
  assign bit_take   = in_valid_i && !in_stall_o;

  abd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .bit_valid_i (bit_take),
    .line_bit_i  (line_bit_i),
    .ev_valid_o  (fr_valid),
    .ev_o        (fr_ev)
  );

  abd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_ev),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_ev)
  );

  abd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (q_valid),
    .ev_i        (q_ev),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_ev_o    (out_ev)
  );

  // result fields
  assign event_kind_o         = out_ev.kind;
  assign data_byte_o          = out_ev.data;
  assign byte_parity_bad_o    = out_ev.pbad;
  assign block_length_o       = out_ev.len;
  assign crc_first_o          = out_ev.crc_first;
  assign crc_second_o         = out_ev.crc_second;
  assign parity_error_count_o = out_ev.perr;

endmodule

// ===== src/abd_checker.sv =====
// ----------------------------------------------------------------------------
// abd_checker
// port-level checks of the acars block deframer, bound to the top level
// ----------------------------------------------------------------------------
module abd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_kind_o,
  input logic [7:0] data_byte_o,
  input logic       byte_parity_bad_o,
  input logic [7:0] block_length_o,
  input logic [7:0] crc_first_o,
  input logic [7:0] crc_second_o,
  input logic [4:0] parity_error_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(data_byte_o) && $stable(byte_parity_bad_o) && $stable(block_length_o) &&
      $stable(crc_first_o) && $stable(crc_second_o) && $stable(parity_error_count_o))
    else $error("result changed while stalled");

  // the input only backs up behind a waiting result
  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // only text events carry a byte
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != abd_pkg::EV_TEXT) |->
      (data_byte_o == 8'd0) && !byte_parity_bad_o)
    else $error("byte fields set on non-text event");

  // only completed blocks carry length and crc
  a_no_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != abd_pkg::EV_DONE) |->
      (block_length_o == 8'd0) && (crc_first_o == 8'd0) && (crc_second_o == 8'd0))
    else $error("block fields set on non-complete event");

  // parity count cannot pass the largest limit setting plus two, and no event has the unused kind
  a_perr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (parity_error_count_o <= 5'd17) && (event_kind_o != 2'd3))
    else $error("result out of range");

endmodule

bind acars_block_deframer abd_checker u_abd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .event_kind_o         (event_kind_o),
  .data_byte_o          (data_byte_o),
  .byte_parity_bad_o    (byte_parity_bad_o),
  .block_length_o       (block_length_o),
  .crc_first_o          (crc_first_o),
  .crc_second_o         (crc_second_o),
  .parity_error_count_o (parity_error_count_o)
);

// ===== verif/acars_block_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// acars_block_deframer_tb
// self-checking bench for the acars block deframer: line bits are sent as
// whole framed blocks and as junk, every event is predicted bit by bit and
// compared field by field as it leaves the block
// ----------------------------------------------------------------------------
module acars_block_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HoldCycles = 400;   // long receiver hold-off
  localparam int         IdleLimit  = 2000;  // cycles without any transfer
  localparam logic [1:0] RegUnused  = 2'd3;  // index past the register list
  localparam logic [7:0] IdleLine   = 8'hFF; // never looks like sync

  typedef enum logic [1:0] {
    END_ETX,
    END_ETB,
    END_DLE,
    END_NONE
  } frame_end_e;

  // bit-accurate copy of the deframer plus the queue of events it owes
  class deframe_scoreboard;
    abd_pkg::cfg_t         cfg;
    abd_pkg::frame_state_e state;
    logic [7:0]            shifter;
    logic [3:0]            bits_left;
    logic                  invert;
    logic [7:0]            text_count;
    logic [4:0]            perr;
    logic [7:0]            last_byte;
    logic [7:0]            prev_byte;
    logic [7:0]            held_crc;
    abd_pkg::frame_ev_t    expected_events[$];
    int                    errors;

    function new();
      cfg.max_parity_errors = abd_pkg::MaxPerrReset;
      cfg.dle_min_length    = abd_pkg::DleMinReset;
      cfg.max_text_length   = abd_pkg::MaxLenReset;
      state      = abd_pkg::ST_WSYN;
      shifter    = '0;
      bits_left  = '0;
      invert     = 1'b0;
      text_count = '0;
      perr       = '0;
      last_byte  = '0;
      prev_byte  = '0;
      held_crc   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        abd_pkg::REG_MAX_PERR: cfg.max_parity_errors = val[3:0];
        abd_pkg::REG_DLE_MIN:  cfg.dle_min_length    = val;
        abd_pkg::REG_MAX_LEN:  cfg.max_text_length   = val;
        default: ;
      endcase
    endfunction

    function void add_event(abd_pkg::event_kind_e kind, logic [7:0] data, logic pbad,
                            logic [7:0] len, logic [7:0] c0, logic [7:0] c1);
      abd_pkg::frame_ev_t ev;
      ev.kind       = kind;
      ev.data       = data;
      ev.pbad       = pbad;
      ev.len        = len;
      ev.crc_first  = c0;
      ev.crc_second = c1;
      ev.perr       = perr;
      expected_events.push_back(ev);
    endfunction

    function void restart_hunt();
      state     = abd_pkg::ST_WSYN;
      bits_left = 4'd1;
    endfunction

    function void abort_block();
      restart_hunt();
      add_event(abd_pkg::EV_ABORT, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
    endfunction

    function void take_text_byte(logic [7:0] b);
      int   count_next;
      logic bad;
      count_next = int'(text_count) + 1;
      bad        = ~^b;
      if (bad) begin
        perr = perr + 5'd1;
        if (int'(perr) > int'(cfg.max_parity_errors) + 1) begin
          abort_block();
          return;
        end
      end
      if (count_next > 255) begin
        abort_block();
        return;
      end
      text_count = 8'(count_next);
      if (b == abd_pkg::EtxByte || b == abd_pkg::EtbByte) begin
        state     = abd_pkg::ST_CRC1;
        bits_left = abd_pkg::BitsPerByte;
        add_event(abd_pkg::EV_TEXT, b, bad, 8'd0, 8'd0, 8'd0);
        return;
      end
      // dle cut: the two bytes before it stand in for the crc
      if (count_next > int'(cfg.dle_min_length) && b == abd_pkg::DleByte) begin
        text_count = (count_next >= 3) ? 8'(count_next - 3) : 8'd0;
        state      = abd_pkg::ST_END;
        bits_left  = abd_pkg::BitsPerByte;
        add_event(abd_pkg::EV_DONE, 8'd0, 1'b0, text_count, prev_byte, last_byte);
        return;
      end
      if (count_next > int'(cfg.max_text_length)) begin
        abort_block();
        return;
      end
      prev_byte = last_byte;
      last_byte = b;
      bits_left = abd_pkg::BitsPerByte;
      add_event(abd_pkg::EV_TEXT, b, bad, 8'd0, 8'd0, 8'd0);
    endfunction

    // one accepted line bit
    function void note_line_bit(logic line_bit);
      logic [7:0] b;
      shifter = {line_bit ^ invert, shifter[7:1]};
      if (bits_left > 4'd1) begin
        bits_left = bits_left - 4'd1;
        return;
      end
      b = shifter;
      case (state)
        abd_pkg::ST_SYN2: begin
          if (b == abd_pkg::SynByte) begin
            state     = abd_pkg::ST_SOH1;
            bits_left = abd_pkg::BitsPerByte;
          end else if (b == abd_pkg::SynInv) begin
            invert    = ~invert;
            bits_left = abd_pkg::BitsPerByte;
          end else begin
            restart_hunt();
          end
        end
        abd_pkg::ST_SOH1: begin
          if (b == abd_pkg::SohByte) begin
            state      = abd_pkg::ST_TXT;
            text_count = '0;
            perr       = '0;
            last_byte  = '0;
            prev_byte  = '0;
            bits_left  = abd_pkg::BitsPerByte;
          end else begin
            restart_hunt();
          end
        end
        abd_pkg::ST_TXT: take_text_byte(b);
        abd_pkg::ST_CRC1: begin
          held_crc  = b;
          state     = abd_pkg::ST_CRC2;
          bits_left = abd_pkg::BitsPerByte;
        end
        abd_pkg::ST_CRC2: begin
          state     = abd_pkg::ST_END;
          bits_left = abd_pkg::BitsPerByte;
          add_event(abd_pkg::EV_DONE, 8'd0, 1'b0, text_count, held_crc, b);
        end
        abd_pkg::ST_END: begin
          state     = abd_pkg::ST_WSYN;
          bits_left = abd_pkg::BitsPerByte;
        end
        default: begin
          if (b == abd_pkg::SynByte) begin
            state     = abd_pkg::ST_SYN2;
            bits_left = abd_pkg::BitsPerByte;
          end else if (b == abd_pkg::SynInv) begin
            invert    = ~invert;
            state     = abd_pkg::ST_SYN2;
            bits_left = abd_pkg::BitsPerByte;
          end else begin
            restart_hunt();
          end
        end
      endcase
    endfunction

    function void compare(string what, int want, int seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      end
    endfunction

    function void check_event(abd_pkg::frame_ev_t got);
      abd_pkg::frame_ev_t want;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: event mismatch, expected none, actual kind %0d", $time, got.kind);
        return;
      end
      want = expected_events.pop_front();
      compare("event_kind", want.kind, got.kind);
      compare("data_byte", want.data, got.data);
      compare("byte_parity_bad", want.pbad, got.pbad);
      compare("block_length", want.len, got.len);
      compare("crc_first", want.crc_first, got.crc_first);
      compare("crc_second", want.crc_second, got.crc_second);
      compare("parity_error_count", want.perr, got.perr);
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       line_bit  = 1'b0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] event_kind_o;
  logic [7:0] data_byte_o;
  logic       byte_parity_bad_o;
  logic [7:0] block_length_o;
  logic [7:0] crc_first_o;
  logic [7:0] crc_second_o;
  logic [4:0] parity_error_count_o;
  logic       cfg_ready_o;

  // bench control
  logic long_hold = 1'b0;  // ask the receiver for one long hold-off
  logic quiet     = 1'b0;  // no idling on either side
  logic line_inv  = 1'b0;  // polarity the sender puts on the line
  int   bits_sent = 0;

  deframe_scoreboard sb;

  always #2 clk = ~clk;

  acars_block_deframer u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .line_bit_i           (line_bit),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .event_kind_o         (event_kind_o),
    .data_byte_o          (data_byte_o),
    .byte_parity_bad_o    (byte_parity_bad_o),
    .block_length_o       (block_length_o),
    .crc_first_o          (crc_first_o),
    .crc_second_o         (crc_second_o),
    .parity_error_count_o (parity_error_count_o),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  // receiver: random stall bursts, plus one long hold-off on request so the
  // event queue fills up and the block has to stall its bit input
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // sampled on the falling edge, away from the rising edge, so the values are settled and
  // are exactly the ones the next rising edge will act on
  always @(negedge clk) begin : result_monitor
    abd_pkg::frame_ev_t got;
    if (rst_n && out_valid_o && !out_stall) begin
      got.kind       = abd_pkg::event_kind_e'(event_kind_o);
      got.data       = data_byte_o;
      got.pbad       = byte_parity_bad_o;
      got.len        = block_length_o;
      got.crc_first  = crc_first_o;
      got.crc_second = crc_second_o;
      got.perr       = parity_error_count_o;
      sb.check_event(got);
    end
  end

  // any transfer on any channel restarts the count
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(negedge clk);
      if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // one line bit transfer, with an optional gap in front of it
  task automatic send_bit(input logic b);
    logic took;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_bit <= b;
    do begin
      @(negedge clk);
      took = !in_stall_o;
      @(posedge clk);
    end while (!took);
    sb.note_line_bit(b);
    bits_sent++;
  endtask

  // lsb first, with the sender's line polarity applied
  task automatic send_byte(input logic [7:0] b);
    for (int i = 0; i < 8; i++)
      send_bit(b[i] ^ line_inv);
  endtask

  // odd parity is good parity; framing codes are kept out of the text
  function automatic logic [7:0] rand_text_byte(input logic bad);
    logic [7:0] b;
    do begin
      b    = 8'($urandom);
      b[7] = bad ? ^b[6:0] : ~^b[6:0];
    end while (b == abd_pkg::EtxByte || b == abd_pkg::EtbByte || b == abd_pkg::DleByte);
    return b;
  endfunction

  task automatic send_frame(input int n_text, input int bad_pct, input frame_end_e fin,
                            input logic flip_sync);
    line_inv = 1'($urandom);
    repeat ($urandom_range(1, 3)) send_byte(IdleLine);
    send_byte(abd_pkg::SynByte);
    // inverted second sync: the block flips, so the sender flips with it
    if (flip_sync) begin
      send_byte(abd_pkg::SynInv);
      line_inv = ~line_inv;
    end
    send_byte(abd_pkg::SynByte);
    send_byte(abd_pkg::SohByte);
    repeat (n_text) send_byte(rand_text_byte($urandom_range(0, 99) < bad_pct));
    case (fin)
      END_ETX, END_ETB: begin
        send_byte((fin == END_ETX) ? abd_pkg::EtxByte : abd_pkg::EtbByte);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
      END_DLE: send_byte(abd_pkg::DleByte);
      default: ;
    endcase
    // trailing byte, swallowed after a completed block
    send_byte(IdleLine);
  endtask

  // sync that falls apart before the text starts
  task automatic send_broken();
    logic [7:0] junk;
    junk = 8'($urandom);
    if (junk == abd_pkg::SohByte || junk == abd_pkg::SynByte || junk == abd_pkg::SynInv)
      junk = 8'h55;
    line_inv = 1'($urandom);
    send_byte(IdleLine);
    send_byte(abd_pkg::SynByte);
    if ($urandom_range(0, 1) == 1)
      send_byte(abd_pkg::SynByte);
    send_byte(junk);
    send_byte(IdleLine);
  endtask

  task automatic send_random_frame();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: send_frame($urandom_range(0, 12), 5, END_ETX, 1'b0);
      3: send_frame($urandom_range(0, 12), 5, END_ETB, 1'($urandom));
      4: begin
        // dle right around the length where it starts to end the block
        if (sb.cfg.dle_min_length < 30)
          n = int'(sb.cfg.dle_min_length) + int'($urandom_range(0, 2)) - 1;
        else
          n = $urandom_range(0, 12);
        if (n < 0)
          n = 0;
        send_frame(n, 5, END_DLE, 1'b0);
      end
      5: send_frame($urandom_range(2, 12), 60, END_ETX, 1'b0);
      6: begin
        // text right around the overlength limit
        if (sb.cfg.max_text_length < 30)
          n = int'(sb.cfg.max_text_length) + int'($urandom_range(0, 2)) - 1;
        else
          n = $urandom_range(0, 12);
        if (n < 0)
          n = 0;
        send_frame(n, 5, END_ETX, 1'b0);
      end
      7: send_broken();
      8: repeat ($urandom_range(8, 40)) send_bit(1'($urandom));
      default: send_frame($urandom_range(0, 12), 5, END_NONE, 1'($urandom));
    endcase
  endtask

  // stop sending and let every owed event come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready_o;
      @(posedge clk);
    end while (!took);
    sb.write_reg(idx, val);
  endtask

  // all registers, plus a stray write that has to be ignored
  task automatic configure(input logic [7:0] perr_val, input logic [7:0] dle_val,
                           input logic [7:0] len_val);
    drain();
    cfg_write(RegUnused, 8'($urandom));
    cfg_write(abd_pkg::REG_MAX_PERR, perr_val);
    cfg_write(abd_pkg::REG_DLE_MIN, dle_val);
    cfg_write(abd_pkg::REG_MAX_LEN, len_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_random();
    configure({4'($urandom), 4'($urandom_range(0, 6))},
              ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 30)),
              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(200, 255))
                                          : 8'($urandom_range(0, 40)));
  endtask

  initial begin : stimulus
    int frames;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset limits; the receiver holds off during the first block
    long_hold = 1'b1;
    send_frame(4, 10, END_ETX, 1'b0);
    send_frame(21, 0, END_DLE, 1'b0);   // dle past the minimum length
    send_frame(5, 100, END_ETX, 1'b1);  // parity abort after inverted second sync

    // tightest limits, junk above the parity limit field; a dle block too
    // short to hold a crc comes out with length zero and a zero crc byte
    configure(8'hF0, 8'd0, 8'd3);
    send_frame(1, 0, END_DLE, 1'b0);
    send_frame(4, 0, END_ETB, 1'b0);    // overlength

    // widest limits: parity count to its top
    configure(8'd15, 8'd255, 8'd255);
    send_frame(17, 100, END_ETX, 1'b0);

    // random blocks and junk, settings changed every few blocks
    frames = 0;
    while (bits_sent < 900) begin
      if (frames % 5 == 0)
        configure_random();
      send_random_frame();
      frames++;
    end

    // last stretch without any idling
    configure_random();
    quiet = 1'b1;
    while (bits_sent < 1150)
      send_random_frame();

    drain();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
